// File: design/assert_macros.svh
// Assertion macros for the design files; included by the controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// File: design/rfdke_pkg.sv
// Shared types and constants of the remote frame decoder.
package rfdke_pkg;

   localparam int FRAME_LEN   = 16;
   localparam int POS_W       = 5;
   localparam int ADDR_W      = 4;
   localparam int TICK_W      = 32;
   localparam int WALK_W      = 5;
   localparam int KEY_OUT_W   = 15;
   localparam int STICK_W     = 11;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 136;

   localparam logic [STICK_W-1:0] STICK_OFFSET    = 11'd1024;
   localparam logic [TICK_W-1:0]  HOLDOFF_DEFAULT = 32'd50;

   // Controller to datapath commands
   typedef struct packed {
      logic              store;
      logic [ADDR_W-1:0] store_addr;
      logic              walk;
      logic [WALK_W-1:0] walk_idx;
      logic              finish;
   } rfdke_cmd_type;

endpackage

// File: design/rfdke_ctrl.sv
// Controller: byte position, timestamp walk sequencing and result handshake.
`include "assert_macros.svh"

module rfdke_ctrl #(
   parameter int NUM_KEYS = 15
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_frame_start,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output rfdke_pkg::rfdke_cmd_type cmd
);
   import rfdke_pkg::*;

   typedef enum logic [1:0] {
      S_COLLECT,
      S_WALK,
      S_LOAD
   } state_type;

   localparam logic [WALK_W-1:0] LAST_IDX = WALK_W'(NUM_KEYS + 1);
   localparam logic [POS_W-1:0]  POS_IDLE = POS_W'(FRAME_LEN);
   localparam logic [POS_W-1:0]  POS_LAST = POS_W'(FRAME_LEN - 1);

   state_type         state_ff, state_in;
   logic [POS_W-1:0]  pos_ff, pos_in, pos_eff;
   logic [WALK_W-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;

   // Hold off the completing byte while the previous result is still pending
   assign req_tready = (state_ff == S_COLLECT) && !(rsp_valid_ff && pos_ff == POS_LAST);
   assign accept     = req_tvalid && req_tready;
   assign pos_eff    = req_frame_start ? '0 : pos_ff;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      unique case (state_ff)
         S_COLLECT: begin
            if (accept && !pos_eff[POS_W-1]) begin
               cmd.store      = 1'b1;
               cmd.store_addr = pos_eff[ADDR_W-1:0];
               pos_in         = pos_eff + 1'b1;
               if (pos_eff == POS_LAST) begin
                  state_in = S_WALK;
                  idx_in   = '0;
               end
            end else if (accept) begin
               pos_in = pos_eff;
            end
         end
         S_WALK: begin
            cmd.walk     = 1'b1;
            cmd.walk_idx = idx_ff;
            if (idx_ff == LAST_IDX) begin
               state_in = S_LOAD;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_LOAD: begin
            cmd.finish = 1'b1;
            state_in   = S_COLLECT;
         end
         default: state_in = S_COLLECT;
      endcase
      rsp_valid_in = (rsp_valid_ff && !rsp_tready) || cmd.finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_COLLECT;
         pos_ff       <= POS_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_NEVER(a_no_overrun, clock, reset,
      cmd.store && cmd.store_addr == ADDR_W'(FRAME_LEN - 1) && rsp_valid_ff,
      "frame completed while result still pending")
   `ASSERT_CLK(a_walk_follows_frame, clock, reset,
      cmd.store && cmd.store_addr == ADDR_W'(FRAME_LEN - 1) |=>
         cmd.walk && cmd.walk_idx == '0,
      "walk did not start after last byte")
   `ASSERT_CLK(a_finish_after_walk, clock, reset,
      cmd.finish |-> $past(cmd.walk && cmd.walk_idx == LAST_IDX),
      "result loaded before walk finished")

endmodule

// File: design/rfdke_dpath.sv
// Datapath: frame store, field unpacking, hold-off compare unit and result register.
module rfdke_dpath #(
   parameter int NUM_KEYS = 15
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rfdke_pkg::rfdke_cmd_type             cmd,
   input  logic [7:0]                           data_byte,
   input  logic [rfdke_pkg::TICK_W-1:0]         tick_now,
   input  logic                                 csr_wr_en,
   input  logic [rfdke_pkg::TICK_W-1:0]         csr_wr_data,
   output logic [rfdke_pkg::RSP_TDATA_W-1:0]    rsp_data
);
   import rfdke_pkg::*;

   localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   logic [7:0]             frame_ff [FRAME_LEN];
   logic [TICK_W-1:0]      tick_ff;
   logic [TICK_W-1:0]      holdoff_ff;
   logic [15:0]            prev_keys_ff;
   logic [1:0]             prev_mouse_ff;
   logic [NUM_KEYS-1:0]    held_edges_ff;
   logic [1:0]             medges_ff;
   logic [TICK_W-1:0]      key_time_ff [NUM_KEYS];
   logic [TICK_W-1:0]      mouse_time_ff [2];
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic [15:0]            keys;
   logic [1:0]             held;
   logic [15:0]            edges16;
   logic [KEY_IDX_W-1:0]   key_idx;
   logic                   is_key, mouse_sel;
   logic [TICK_W-1:0]      last_time, elapsed;
   logic                   passed, key_rise, mouse_rise;
   logic [STICK_W-1:0]     stick1, stick2, stick3, stick4;

   assign keys = {frame_ff[15], frame_ff[14]};
   assign held = {|frame_ff[13], |frame_ff[12]};

   // Channels are packed little-endian; subtracting 1024 wraps at 11 bits
   assign stick1 = {frame_ff[1][2:0], frame_ff[0]} - STICK_OFFSET;
   assign stick2 = {frame_ff[2][5:0], frame_ff[1][7:3]} - STICK_OFFSET;
   assign stick3 = {frame_ff[4][0], frame_ff[3], frame_ff[2][7:6]} - STICK_OFFSET;
   assign stick4 = {frame_ff[5][3:0], frame_ff[4][7:1]} - STICK_OFFSET;

   // One shared compare unit, one button per walk step: keys first, then mice
   assign is_key     = cmd.walk_idx < WALK_W'(NUM_KEYS);
   assign key_idx    = cmd.walk_idx[KEY_IDX_W-1:0];
   assign mouse_sel  = cmd.walk_idx != WALK_W'(NUM_KEYS);
   assign last_time  = is_key ? key_time_ff[key_idx] : mouse_time_ff[mouse_sel];
   assign elapsed    = tick_ff - last_time;
   assign passed     = elapsed >= holdoff_ff;
   assign key_rise   = keys[cmd.walk_idx[3:0]] & ~prev_keys_ff[cmd.walk_idx[3:0]];
   assign mouse_rise = held[mouse_sel] & ~prev_mouse_ff[mouse_sel];

   assign edges16  = 16'(held_edges_ff);
   assign rsp_data = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         holdoff_ff    <= HOLDOFF_DEFAULT;
         prev_keys_ff  <= '0;
         prev_mouse_ff <= '0;
         held_edges_ff <= '0;
         medges_ff     <= '0;
         for (int i = 0; i < NUM_KEYS; i++) begin
            key_time_ff[i] <= '0;
         end
         mouse_time_ff[0] <= '0;
         mouse_time_ff[1] <= '0;
      end else begin
         if (csr_wr_en) begin
            holdoff_ff <= csr_wr_data;
         end
         if (cmd.walk) begin
            if (is_key) begin
               if (passed) begin
                  if (key_rise) begin
                     held_edges_ff[key_idx] <= 1'b1;
                     key_time_ff[key_idx]   <= tick_ff;
                  end
               end else begin
                  held_edges_ff[key_idx] <= 1'b0;
               end
            end else if (passed && mouse_rise) begin
               medges_ff[mouse_sel]     <= 1'b1;
               mouse_time_ff[mouse_sel] <= tick_ff;
            end
         end
         if (cmd.finish) begin
            prev_keys_ff  <= keys;
            prev_mouse_ff <= held;
            medges_ff     <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         frame_ff[cmd.store_addr] <= data_byte;
         tick_ff                  <= tick_now;
      end
      if (cmd.finish) begin
         rsp_data_ff <= {5'b0, medges_ff, edges16[KEY_OUT_W-1:0], keys, held,
                         frame_ff[11], frame_ff[10], frame_ff[9], frame_ff[8],
                         frame_ff[7], frame_ff[6], frame_ff[5][7:4],
                         stick4, stick3, stick2, stick1};
      end
   end

endmodule

// File: design/remote_frame_decode_key_edges_top.sv
// Top level of the remote-receiver frame decoder with debounced press edges.
//
// Takes remote-receiver frame bytes, one per req transaction, and after the
// 16th byte of a frame returns one rsp transaction with the unpacked sticks,
// switches, mouse axes and buttons, key mask and debounced press edges.
// A byte with the frame-start flag (req_tuser) always restarts a frame at
// byte 0; bytes outside a frame are dropped without a result, and partial
// frames give none. The 16th byte starts a walk over NUM_KEYS + 2 buttons
// through a single hold-off compare unit (one 32-bit subtract and compare
// per cycle), followed by a load step that writes the result register, so
// req_tready is low from the last byte of a frame until that load. A result
// held in the output register does not block the next frame's bytes; only
// the byte that would complete the next frame waits for it to be taken.
// The hold-off count is written on the csr port; the user must write it only
// while no frame is in flight, which the block does not enforce. It resets
// to 50 ticks, and elapsed time is counted modulo 2^32.
module remote_frame_decode_key_edges_top #(
   parameter int NUM_KEYS = 15
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata, low bit up: data_byte[7:0], tick_now[31:0]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rfdke_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_tuser: frame_start
   input  logic                                 req_tuser,
   // rsp_tdata, low bit up: stick_one[10:0], stick_two[10:0], stick_three[10:0],
   // stick_four[10:0], switch_pair[3:0], mouse_dx[15:0], mouse_dy[15:0],
   // mouse_dz[15:0], mouse_held[1:0], key_mask[15:0], key_edges[14:0],
   // mouse_edges[1:0], zero fill[4:0]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rfdke_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // hold-off ticks register
   input  logic                                 csr_wr_en,
   input  logic [rfdke_pkg::TICK_W-1:0]         csr_wr_data
);
   import rfdke_pkg::*;

   rfdke_cmd_type cmd;

   rfdke_ctrl #(
      .NUM_KEYS (NUM_KEYS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_frame_start (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .cmd             (cmd)
   );

   rfdke_dpath #(
      .NUM_KEYS (NUM_KEYS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_tdata[7:0]),
      .tick_now    (req_tdata[8 +: TICK_W]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_data    (rsp_tdata)
   );

endmodule
